// ===== design/tcw_pkg.sv =====
// Package for the text console writer: geometry, codes, payload and op types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int CELL_AW = $clog2(CELLS);
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'h20;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_CLEAR,
      OP_READ,
      OP_NOP
   } op_kind_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [7:0]       char_code;
      logic [ROW_W-1:0] cell_row;
      logic [COL_W-1:0] cell_column;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0] cursor_column;
      logic [ROW_W-1:0] cursor_row;
      logic             screen_cleared;
      logic [7:0]       cell_char;
   } rsp_type;

   typedef struct packed {
      op_kind_type        kind;
      logic [7:0]         char_code;
      logic [CELL_AW-1:0] cell_addr;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } op_chan_type;

endpackage : tcw_pkg
`default_nettype wire

// ===== design/tcw_front.sv =====
// Front end: classifies an accepted request into an op and forms the cell address.
// Depends on tcw_pkg.
`default_nettype none
module tcw_front
   import tcw_pkg::*;
(
   input  wire req_type req_payload,
   output op_type       op
);

   logic in_range;

   always_comb begin
      in_range = (req_payload.cell_row < ROW_W'(ROWS)) &&
                 ({1'b0, req_payload.cell_column} < (COL_W + 1)'(COLUMNS));
      op.char_code = req_payload.char_code;
      op.cell_addr = CELL_AW'(req_payload.cell_row) * CELL_AW'(COLUMNS) +
                     CELL_AW'(req_payload.cell_column);
      case (req_payload.command)
         CMD_PUT: begin
            op.kind = (req_payload.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
         end
         CMD_CLEAR: begin
            op.kind = OP_CLEAR;
         end
         CMD_READ: begin
            op.kind = in_range ? OP_READ : OP_NOP;
         end
         default: begin
            op.kind = OP_NOP;
         end
      endcase
   end

endmodule : tcw_front
`default_nettype wire

// ===== design/tcw_fifo.sv =====
// Short op queue between front and back end.
// Depends on tcw_pkg.
`default_nettype none
module tcw_fifo
   import tcw_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          push,
   input  wire op_type  push_op,
   output logic         full,
   input  wire          pop,
   output op_chan_type  head
);

   op_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;

   always_comb begin
      full       = (count_ff == (FIFO_AW + 1)'(FIFO_DEPTH));
      head.valid = (count_ff != '0);
      head.op    = mem_ff[rd_ptr_ff];
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule : tcw_fifo
`default_nettype wire

// ===== design/tcw_back.sv =====
// Back end: character store, cursor, clear sweep and result register.
// Depends on tcw_pkg; fed by tcw_fifo.
`default_nettype none
module tcw_back
   import tcw_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire op_chan_type head,
   output logic        pop,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output rsp_type     rsp_payload
);

   typedef enum logic [1:0] {
      S_SWEEP,
      S_RUN,
      S_READ
   } state_type;

   logic [7:0]         store [CELLS];
   logic [7:0]         rd_data_ff;

   state_type          state_ff, state_in;
   logic [CELL_AW-1:0] sweep_ff, sweep_in;
   logic               pend_ff, pend_in;
   logic [COL_W-1:0]   x_ff, x_in;
   logic [ROW_W-1:0]   y_ff, y_in;
   logic [CELL_AW-1:0] addr_ff, addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               out_free;
   logic               wr_en;
   logic [CELL_AW-1:0] wr_addr;
   logic [7:0]         wr_data;
   logic               rd_en;
   logic [COL_W-1:0]   nx;
   logic [ROW_W:0]     ny;
   logic [CELL_AW-1:0] naddr;

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      pend_in      = pend_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = head.op.char_code;
      rd_en        = 1'b0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      nx           = '0;
      ny           = {1'b0, y_ff} + 1'b1;
      naddr        = addr_ff + CELL_AW'(COLUMNS) - CELL_AW'(x_ff);
      if (head.op.kind == OP_PUT) begin
         naddr = addr_ff + 1'b1;
         if (x_ff != COL_W'(COLUMNS - 1)) begin
            nx = x_ff + 1'b1;
            ny = {1'b0, y_ff};
         end
      end

      case (state_ff)
         S_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = SPACE_CODE;
            if (sweep_ff == CELL_AW'(CELLS - 1)) begin
               state_in = S_RUN;
               x_in     = '0;
               y_in     = '0;
               addr_in  = '0;
               pend_in  = 1'b0;
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{cursor_column: '0, cursor_row: '0,
                                   screen_cleared: 1'b1, cell_char: '0};
               end
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_RUN: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               case (head.op.kind)
                  OP_PUT, OP_NEWLINE: begin
                     wr_en = (head.op.kind == OP_PUT);
                     if (ny == (ROW_W + 1)'(ROWS)) begin
                        state_in = S_SWEEP;
                        sweep_in = '0;
                        pend_in  = 1'b1;
                     end else begin
                        x_in         = nx;
                        y_in         = ny[ROW_W-1:0];
                        addr_in      = naddr;
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{cursor_column: nx, cursor_row: ny[ROW_W-1:0],
                                         screen_cleared: 1'b0, cell_char: '0};
                     end
                  end
                  OP_CLEAR: begin
                     state_in = S_SWEEP;
                     sweep_in = '0;
                     pend_in  = 1'b1;
                  end
                  OP_READ: begin
                     rd_en    = 1'b1;
                     state_in = S_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{cursor_column: x_ff, cursor_row: y_ff,
                                      screen_cleared: 1'b0, cell_char: '0};
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               state_in     = S_RUN;
               rsp_valid_in = 1'b1;
               rsp_in       = '{cursor_column: x_ff, cursor_row: y_ff,
                                screen_cleared: 1'b0, cell_char: rd_data_ff};
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store[head.op.cell_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule : tcw_back
`default_nettype wire

// ===== design/text_console_writer_unit.sv =====
// Top level of the text console writer: front end, op queue, back end.
// Depends on tcw_pkg, tcw_front, tcw_fifo and tcw_back.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_type (command, char, cell)
//   rsp_      out        rsp_valid/rsp_stall  rsp_type (cursor, cleared, char)
//
// Put and newline: one item per cycle through the back end while rsp_stall is
// low; the result follows in the cycle after the op leaves the queue, unless the
// op runs off the last row. Read: the store read is registered, then the result.
// Clear, or a put/newline that runs off the last row: one pass over the store,
// one cell written per cycle, then the result. After reset the same pass runs
// and requests queue up to the queue depth; req_stall is high while queue is full.
`default_nettype none
module text_console_writer_unit
   import tcw_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output rsp_type      rsp_payload
);

   op_type      front_op;
   op_chan_type head;
   logic        full;
   logic        pop;

   tcw_front u_front (
      .req_payload (req_payload),
      .op          (front_op)
   );

   tcw_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_valid && !full),
      .push_op (front_op),
      .full    (full),
      .pop     (pop),
      .head    (head)
   );

   tcw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   assign req_stall = full;

endmodule : text_console_writer_unit
`default_nettype wire

// ===== design/tcw_checker.sv =====
// Port-level checks for text_console_writer_unit, bound to the top level.
// Depends on tcw_pkg.
`default_nettype none
module tcw_checker
   import tcw_pkg::*;
(
   input wire          clock,
   input wire          reset,
   input wire          rsp_valid,
   input wire          rsp_stall,
   input wire rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.cursor_column < COL_W'(COLUMNS)) &&
                    (rsp_payload.cursor_row < ROW_W'(ROWS)))
      else $error("cursor outside screen");

   a_clear_home: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.screen_cleared |->
         rsp_payload.cursor_column == '0 && rsp_payload.cursor_row == '0)
      else $error("clear left cursor away from home");

   a_read_no_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.cell_char != '0) |-> !rsp_payload.screen_cleared)
      else $error("read result flagged as clear");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule : tcw_checker

bind text_console_writer_unit tcw_checker u_tcw_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
